// ----- src/rmj_pkg.sv -----
// Shared types, widths and the saturating pack function for the radar Jacobian core.
package rmj_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 32;
    localparam int MUL_CHUNK = 32;
    localparam int MUL_LAT   = 3;
    localparam int SQ_W      = 2 * WORD_W;
    localparam int SUM_W     = 2 * WORD_W + 1;
    localparam int QUO_W     = 2 * WORD_W + 1;
    localparam int MAG_W     = QUO_W;

    localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (WORD_W - 1);
    localparam logic [MAG_W-1:0] LIM_POS = LIM_NEG - MAG_W'(1);

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
    } target_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] range_dpx;
        logic signed [WORD_W-1:0] range_dpy;
        logic signed [WORD_W-1:0] bearing_dpx;
        logic signed [WORD_W-1:0] bearing_dpy;
        logic signed [WORD_W-1:0] rate_dpx;
        logic signed [WORD_W-1:0] rate_dpy;
        logic                     div_zero;
    } jacobian_t;

    typedef struct packed {
        logic [WORD_W-1:0] p;
        logic [WORD_W-1:0] q;
        logic              pn;
        logic              qn;
        logic              un;
        logic              vn;
    } side1_t;

    typedef struct packed {
        logic [SUM_W-1:0]  s;
        logic [SQ_W-1:0]   p2;
        logic [SQ_W-1:0]   q2;
        logic [WORD_W-1:0] p;
        logic [WORD_W-1:0] q;
        logic              pn;
        logic              qn;
        logic              ds;
        logic              dz;
    } side2_t;

    typedef struct packed {
        logic pn;
        logic qn;
        logic ds;
        logic dz;
    } side4_t;

    typedef struct packed {
        logic [WORD_W-1:0] out2;
        logic [WORD_W-1:0] out3;
        logic              pn;
        logic              qn;
        logic              ds;
        logic              dz;
        logic              ovf0;
        logic              ovf1;
        logic              ovf4;
        logic              ovf5;
    } side5_t;

    // Clamp a magnitude to the signed word range, then apply the sign.
    function automatic logic [WORD_W-1:0] sat_pack(
        input logic [MAG_W-1:0] mag,
        input logic             over,
        input logic             neg
    );
        logic [MAG_W-1:0]  lim;
        logic [WORD_W-1:0] v;
        lim = neg ? LIM_NEG : LIM_POS;
        v   = (over || (mag > lim)) ? lim[WORD_W-1:0] : mag[WORD_W-1:0];
        return neg ? (~v + WORD_W'(1)) : v;
    endfunction

endpackage

// ----- src/rmj_dly.sv -----
// Delay line carrying a valid bit and sideband alongside a pipelined unit.
module rmj_dly #(
    parameter int DW    = 8,
    parameter int DEPTH = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    output logic [DW-1:0] out_data
);

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DW-1:0]    dat_reg [DEPTH];

    assign vld_next = (vld_reg << 1) | DEPTH'(in_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dat_reg[0] <= in_data;
        for (int k = 1; k < DEPTH; k++)
        begin
            dat_reg[k] <= dat_reg[k-1];
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = dat_reg[DEPTH-1];

endmodule

// ----- src/rmj_mul.sv -----
// Three-stage unsigned multiplier built from 32x32 partial products.
module rmj_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic            clk,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic [AW+BW-1:0] p
);

    localparam int CW = rmj_pkg::MUL_CHUNK;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int PW = AW + BW;

    logic [NA*CW-1:0] a_pad;
    logic [NB*CW-1:0] b_pad;
    logic [2*CW-1:0]  pp_next [NA][NB];
    logic [2*CW-1:0]  pp_reg  [NA][NB];
    logic [PW-1:0]    row_next [NB];
    logic [PW-1:0]    row_reg  [NB];
    logic [PW-1:0]    p_next;
    logic [PW-1:0]    p_reg;

    assign a_pad = (NA*CW)'(a);
    assign b_pad = (NB*CW)'(b);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i][j] = a_pad[i*CW +: CW] * b_pad[j*CW +: CW];
            end
        end
    end

    // sums are exact modulo 2^PW, which the full product fits
    always_comb
    begin
        for (int j = 0; j < NB; j++)
        begin
            row_next[j] = '0;
            for (int i = 0; i < NA; i++)
            begin
                row_next[j] = row_next[j] + (PW'(pp_reg[i][j]) << (CW * i));
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int j = 0; j < NB; j++)
        begin
            p_next = p_next + (row_reg[j] << (CW * j));
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg  <= pp_next;
        row_reg <= row_next;
        p_reg   <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- src/rmj_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rmj_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QB = 32
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quo,
    output logic          ovf
);

    localparam int XW = NW + QB;
    localparam int CW = (NW > DW) ? NW : DW;

    logic [XW-1:0] num_ext;
    logic [DW:0]   trial   [QB];
    logic          ge      [QB];
    logic [DW-1:0] rem_next[QB];

    logic [DW-1:0] rem_reg [QB+1];
    logic [DW-1:0] den_reg [QB+1];
    logic [QB-1:0] low_reg [QB+1];
    logic [QB-1:0] quo_reg [QB+1];
    logic          ovf_reg [QB+1];

    assign num_ext = XW'(num);

    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            trial[k]    = {rem_reg[k], low_reg[k][QB-1]};
            ge[k]       = trial[k] >= {1'b0, den_reg[k]};
            rem_next[k] = ge[k] ? DW'(trial[k] - {1'b0, den_reg[k]}) : trial[k][DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= CW'(num_ext[XW-1:QB]) >= CW'(den);
        rem_reg[0] <= DW'(num_ext[XW-1:QB]);
        low_reg[0] <= num_ext[QB-1:0];
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        for (int k = 0; k < QB; k++)
        begin
            rem_reg[k+1] <= rem_next[k];
            low_reg[k+1] <= low_reg[k] << 1;
            quo_reg[k+1] <= {quo_reg[k][QB-2:0], ge[k]};
            den_reg[k+1] <= den_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    assign quo = quo_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

// ----- src/rmj_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module rmj_sqrt #(
    parameter int XW = 66
) (
    input  logic             clk,
    input  logic [XW-1:0]    x,
    output logic [XW/2-1:0]  root
);

    localparam int RW = XW / 2;

    logic [RW+1:0] cur_rem  [RW];
    logic [RW-1:0] cur_root [RW];
    logic [XW-1:0] cur_xs   [RW];
    logic [RW+3:0] t        [RW];
    logic [RW+3:0] trial    [RW];
    logic          ge       [RW];
    logic [RW+1:0] rem_next [RW];
    logic [RW-1:0] root_next[RW];

    logic [RW+1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [XW-1:0] xs_reg   [RW];

    always_comb
    begin
        for (int k = 0; k < RW; k++)
        begin
            if (k == 0)
            begin
                cur_rem[k]  = '0;
                cur_root[k] = '0;
                cur_xs[k]   = x;
            end
            else
            begin
                cur_rem[k]  = rem_reg[k-1];
                cur_root[k] = root_reg[k-1];
                cur_xs[k]   = xs_reg[k-1];
            end
            t[k]         = {cur_rem[k], cur_xs[k][XW-1:XW-2]};
            trial[k]     = (RW+4)'({cur_root[k], 2'b01});
            ge[k]        = t[k] >= trial[k];
            rem_next[k]  = ge[k] ? (RW+2)'(t[k] - trial[k]) : (RW+2)'(t[k]);
            root_next[k] = {cur_root[k][RW-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RW; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            xs_reg[k]   <= cur_xs[k] << 2;
        end
    end

    assign root = root_reg[RW-1];

endmodule

// ----- src/radar_measurement_jacobian_core.sv -----
// Top level: radar measurement Jacobian pipeline with threshold register.
// One state vector is taken per clock (busy stays low) and its Jacobian entries appear on
// jacobian with done high for one cycle, through 1 input stage, three multiplier rounds,
// 1 sum stage, the 66-stage restoring dividers, the 33-stage square roots and the output
// register. Results cannot be held off, so done must be taken when it comes. The user is
// to write min_range_sq through cfg_valid and cfg_ready (always ready) only while no item
// is in flight; the block does not enforce this. A squared range at or below it sets
// div_zero and zeroes the six entries. Entries are truncated toward zero and saturate.
module radar_measurement_jacobian_core #(
    parameter int FRAC_BITS = rmj_pkg::FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rmj_pkg::target_t              target,
    output logic                          done,
    output rmj_pkg::jacobian_t            jacobian,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rmj_pkg::CFG_W-1:0]     cfg_data
);

    localparam int W        = rmj_pkg::WORD_W;
    localparam int SW       = rmj_pkg::SUM_W;
    localparam int QW       = rmj_pkg::SQ_W;
    localparam int QB       = rmj_pkg::QUO_W;
    localparam int THR_W    = rmj_pkg::CFG_W + FRAC_BITS;
    localparam int CMP_W    = (SW > THR_W) ? SW : THR_W;
    localparam int A_W      = W + SW;
    localparam int S2_W     = 2 * SW;
    localparam int S3_W     = 3 * SW;
    localparam int A2_W     = 2 * A_W;
    localparam int N0_W     = QW + 2 * FRAC_BITS;
    localparam int N2_W     = W + 2 * FRAC_BITS;
    localparam int N4_W     = A2_W + 2 * FRAC_BITS;
    localparam int DIV_LAT  = QB + 1;
    localparam int SQ_XW    = QB + 1;
    localparam int SQ_LAT   = SQ_XW / 2;
    localparam int RT_W     = SQ_XW / 2;
    localparam int LM       = rmj_pkg::MUL_LAT;

    logic [rmj_pkg::CFG_W-1:0] thr_reg;

    // input stage
    logic          vld0_reg;
    rmj_pkg::side1_t s0_next;
    rmj_pkg::side1_t s0_reg;
    logic [W-1:0]  u_next, v_next, u_reg, v_reg;

    // round one
    logic [QW-1:0] p2, q2, t1, t2;
    logic          vld1;
    rmj_pkg::side1_t s1;

    // sum stage
    logic [SW-1:0] s_sum;
    logic [SW-1:0] dm_next;
    logic          ds_next;
    logic          sg1, sg2;
    logic          dz_next;
    rmj_pkg::side2_t s2_next;
    rmj_pkg::side2_t s2_reg;
    logic [SW-1:0] dm_reg;
    logic          vld2_reg;

    // rounds two and three
    logic [S2_W-1:0] ss;
    logic [A_W-1:0]  qd, pd;
    logic            vld3;
    rmj_pkg::side2_t s3;
    logic [S3_W-1:0] sss;
    logic [A2_W-1:0] qd2, pd2;
    logic            vld4;
    rmj_pkg::side2_t s4;

    // division
    logic [QB-1:0] quo [6];
    logic          ovf [6];
    logic          vld5;
    rmj_pkg::side4_t s5_in;
    rmj_pkg::side4_t s5;

    // square roots
    logic [RT_W-1:0] rt [4];
    logic            vld6;
    rmj_pkg::side5_t s6_in;
    rmj_pkg::side5_t s6;

    rmj_pkg::jacobian_t jac_next;
    rmj_pkg::jacobian_t jac_reg;
    logic               done_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_comb
    begin
        s0_next.pn = target.pos_x[W-1];
        s0_next.qn = target.pos_y[W-1];
        s0_next.un = target.vel_x[W-1];
        s0_next.vn = target.vel_y[W-1];
        s0_next.p  = s0_next.pn ? (~target.pos_x + W'(1)) : target.pos_x;
        s0_next.q  = s0_next.qn ? (~target.pos_y + W'(1)) : target.pos_y;
        u_next     = s0_next.un ? (~target.vel_x + W'(1)) : target.vel_x;
        v_next     = s0_next.vn ? (~target.vel_y + W'(1)) : target.vel_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        u_reg  <= u_next;
        v_reg  <= v_next;
    end

    rmj_mul #(.AW(W), .BW(W)) u_mul_pp (.clk(clk), .a(s0_reg.p), .b(s0_reg.p), .p(p2));
    rmj_mul #(.AW(W), .BW(W)) u_mul_qq (.clk(clk), .a(s0_reg.q), .b(s0_reg.q), .p(q2));
    rmj_mul #(.AW(W), .BW(W)) u_mul_uq (.clk(clk), .a(u_reg), .b(s0_reg.q), .p(t1));
    rmj_mul #(.AW(W), .BW(W)) u_mul_vp (.clk(clk), .a(v_reg), .b(s0_reg.p), .p(t2));

    rmj_dly #(.DW($bits(rmj_pkg::side1_t)), .DEPTH(LM)) u_dly1 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(vld0_reg), .in_data(s0_reg),
        .out_valid(vld1), .out_data(s1)
    );

    // r^2, threshold test and signed vx*py - vy*px as magnitude and sign
    always_comb
    begin
        s_sum   = SW'(p2) + SW'(q2);
        dz_next = CMP_W'(s_sum) <= (CMP_W'(thr_reg) << FRAC_BITS);
        sg1     = s1.un ^ s1.qn;
        sg2     = ~(s1.vn ^ s1.pn);
        if (sg1 == sg2)
        begin
            dm_next = SW'(t1) + SW'(t2);
            ds_next = sg1;
        end
        else if (t1 >= t2)
        begin
            dm_next = SW'(t1 - t2);
            ds_next = sg1;
        end
        else
        begin
            dm_next = SW'(t2 - t1);
            ds_next = sg2;
        end
        s2_next.s  = s_sum;
        s2_next.p2 = p2;
        s2_next.q2 = q2;
        s2_next.p  = s1.p;
        s2_next.q  = s1.q;
        s2_next.pn = s1.pn;
        s2_next.qn = s1.qn;
        s2_next.ds = ds_next;
        s2_next.dz = dz_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld2_reg <= vld1;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
        dm_reg <= dm_next;
    end

    rmj_mul #(.AW(SW), .BW(SW)) u_mul_ss (.clk(clk), .a(s2_reg.s), .b(s2_reg.s), .p(ss));
    rmj_mul #(.AW(W), .BW(SW))  u_mul_qd (.clk(clk), .a(s2_reg.q), .b(dm_reg), .p(qd));
    rmj_mul #(.AW(W), .BW(SW))  u_mul_pd (.clk(clk), .a(s2_reg.p), .b(dm_reg), .p(pd));

    rmj_dly #(.DW($bits(rmj_pkg::side2_t)), .DEPTH(LM)) u_dly2 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(vld2_reg), .in_data(s2_reg),
        .out_valid(vld3), .out_data(s3)
    );

    rmj_mul #(.AW(S2_W), .BW(SW)) u_mul_sss (.clk(clk), .a(ss), .b(s3.s), .p(sss));
    rmj_mul #(.AW(A_W), .BW(A_W)) u_mul_qd2 (.clk(clk), .a(qd), .b(qd), .p(qd2));
    rmj_mul #(.AW(A_W), .BW(A_W)) u_mul_pd2 (.clk(clk), .a(pd), .b(pd), .p(pd2));

    rmj_dly #(.DW($bits(rmj_pkg::side2_t)), .DEPTH(LM)) u_dly3 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(vld3), .in_data(s3),
        .out_valid(vld4), .out_data(s4)
    );

    rmj_div #(.NW(N0_W), .DW(SW), .QB(QB)) u_div0 (
        .clk(clk), .num(N0_W'(s4.p2) << (2 * FRAC_BITS)), .den(s4.s),
        .quo(quo[0]), .ovf(ovf[0])
    );
    rmj_div #(.NW(N0_W), .DW(SW), .QB(QB)) u_div1 (
        .clk(clk), .num(N0_W'(s4.q2) << (2 * FRAC_BITS)), .den(s4.s),
        .quo(quo[1]), .ovf(ovf[1])
    );
    rmj_div #(.NW(N2_W), .DW(SW), .QB(QB)) u_div2 (
        .clk(clk), .num(N2_W'(s4.q) << (2 * FRAC_BITS)), .den(s4.s),
        .quo(quo[2]), .ovf(ovf[2])
    );
    rmj_div #(.NW(N2_W), .DW(SW), .QB(QB)) u_div3 (
        .clk(clk), .num(N2_W'(s4.p) << (2 * FRAC_BITS)), .den(s4.s),
        .quo(quo[3]), .ovf(ovf[3])
    );
    rmj_div #(.NW(N4_W), .DW(S3_W), .QB(QB)) u_div4 (
        .clk(clk), .num(N4_W'(qd2) << (2 * FRAC_BITS)), .den(sss),
        .quo(quo[4]), .ovf(ovf[4])
    );
    rmj_div #(.NW(N4_W), .DW(S3_W), .QB(QB)) u_div5 (
        .clk(clk), .num(N4_W'(pd2) << (2 * FRAC_BITS)), .den(sss),
        .quo(quo[5]), .ovf(ovf[5])
    );

    always_comb
    begin
        s5_in.pn = s4.pn;
        s5_in.qn = s4.qn;
        s5_in.ds = s4.ds;
        s5_in.dz = s4.dz;
    end

    rmj_dly #(.DW($bits(rmj_pkg::side4_t)), .DEPTH(DIV_LAT)) u_dly4 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(vld4), .in_data(s5_in),
        .out_valid(vld5), .out_data(s5)
    );

    rmj_sqrt #(.XW(SQ_XW)) u_sqrt0 (.clk(clk), .x(SQ_XW'(quo[0])), .root(rt[0]));
    rmj_sqrt #(.XW(SQ_XW)) u_sqrt1 (.clk(clk), .x(SQ_XW'(quo[1])), .root(rt[1]));
    rmj_sqrt #(.XW(SQ_XW)) u_sqrt4 (.clk(clk), .x(SQ_XW'(quo[4])), .root(rt[2]));
    rmj_sqrt #(.XW(SQ_XW)) u_sqrt5 (.clk(clk), .x(SQ_XW'(quo[5])), .root(rt[3]));

    // bearing row is final after division
    always_comb
    begin
        s6_in.out2 = rmj_pkg::sat_pack(quo[2], ovf[2], !s5.qn);
        s6_in.out3 = rmj_pkg::sat_pack(quo[3], ovf[3], s5.pn);
        s6_in.pn   = s5.pn;
        s6_in.qn   = s5.qn;
        s6_in.ds   = s5.ds;
        s6_in.dz   = s5.dz;
        s6_in.ovf0 = ovf[0];
        s6_in.ovf1 = ovf[1];
        s6_in.ovf4 = ovf[4];
        s6_in.ovf5 = ovf[5];
    end

    rmj_dly #(.DW($bits(rmj_pkg::side5_t)), .DEPTH(SQ_LAT)) u_dly5 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(vld5), .in_data(s6_in),
        .out_valid(vld6), .out_data(s6)
    );

    always_comb
    begin
        jac_next.range_dpx   = rmj_pkg::sat_pack(QB'(rt[0]), s6.ovf0, s6.pn);
        jac_next.range_dpy   = rmj_pkg::sat_pack(QB'(rt[1]), s6.ovf1, s6.qn);
        jac_next.bearing_dpx = s6.out2;
        jac_next.bearing_dpy = s6.out3;
        jac_next.rate_dpx    = rmj_pkg::sat_pack(QB'(rt[2]), s6.ovf4, s6.qn ^ s6.ds);
        jac_next.rate_dpy    = rmj_pkg::sat_pack(QB'(rt[3]), s6.ovf5, !(s6.pn ^ s6.ds));
        jac_next.div_zero    = s6.dz;
        if (s6.dz)
        begin
            jac_next.range_dpx   = '0;
            jac_next.range_dpy   = '0;
            jac_next.bearing_dpx = '0;
            jac_next.bearing_dpy = '0;
            jac_next.rate_dpx    = '0;
            jac_next.rate_dpy    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld6;
        end
    end

    always_ff @(posedge clk)
    begin
        jac_reg <= jac_next;
    end

    assign done     = done_reg;
    assign jacobian = jac_reg;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for radar_measurement_jacobian_core: directed table, then random states.
module tb_top;

    typedef logic [319:0] wide_t;

    typedef struct {
        logic [31:0]         thr;
        rmj_pkg::target_t    tgt;
        logic                chk;
        rmj_pkg::jacobian_t  exp;
    } stim_row_t;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 130;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    rmj_pkg::target_t   target = '0;
    logic               done;
    rmj_pkg::jacobian_t jacobian;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [31:0]        cfg_data = '0;

    logic               busy_s = 1'b1;
    logic               cfg_ready_s = 1'b0;
    logic [31:0]        min_range_sq_m = '0;
    rmj_pkg::jacobian_t jac_pending[$];
    int                 n_fails = 0;
    int                 n_cycles = 0;
    stim_row_t          rows[$];

    radar_measurement_jacobian_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .target    (target),
        .done      (done),
        .jacobian  (jacobian),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        busy_s      <= busy;
        cfg_ready_s <= cfg_ready;
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic wide_t isqrt_w(input wide_t a);
        wide_t res;
        wide_t cand;
        res = '0;
        for (int i = 127; i >= 0; i--)
        begin
            cand = res | (wide_t'(1) << i);
            if (cand * cand <= a)
                res = cand;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp_word(input wide_t m, input logic neg);
        wide_t       lim;
        logic [31:0] v;
        lim = neg ? (wide_t'(1) << 31) : ((wide_t'(1) << 31) - 1);
        v   = (m > lim) ? lim[31:0] : m[31:0];
        return neg ? (~v + 32'd1) : v;
    endfunction

    function automatic wide_t mag_w(input logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return wide_t'(m);
    endfunction

    function automatic rmj_pkg::jacobian_t jacobian_predict(input rmj_pkg::target_t t,
                                                            input logic [31:0] thr);
        rmj_pkg::jacobian_t j;
        wide_t     p, q, u, v, p2, q2, s, s3, t1, t2, dm, n;
        logic      pn, qn, un, vn, s1, s2, ds;
        pn = t.pos_x[31];
        qn = t.pos_y[31];
        un = t.vel_x[31];
        vn = t.vel_y[31];
        p  = mag_w(t.pos_x);
        q  = mag_w(t.pos_y);
        u  = mag_w(t.vel_x);
        v  = mag_w(t.vel_y);
        p2 = p * p;
        q2 = q * q;
        s  = p2 + q2;
        j  = '0;
        if (s <= (wide_t'(thr) << rmj_pkg::FRAC_BITS))
        begin
            j.div_zero = 1'b1;
            return j;
        end
        j.range_dpx   = clamp_word(isqrt_w((p2 << 32) / s), pn);
        j.range_dpy   = clamp_word(isqrt_w((q2 << 32) / s), qn);
        j.bearing_dpx = clamp_word((q << 32) / s, !qn);
        j.bearing_dpy = clamp_word((p << 32) / s, pn);
        t1 = u * q;
        s1 = un ^ qn;
        t2 = v * p;
        s2 = !(vn ^ pn);
        if (s1 == s2)
        begin
            dm = t1 + t2;
            ds = s1;
        end
        else if (t1 >= t2)
        begin
            dm = t1 - t2;
            ds = s1;
        end
        else
        begin
            dm = t2 - t1;
            ds = s2;
        end
        s3 = s * s * s;
        n  = q * dm;
        j.rate_dpx = clamp_word(isqrt_w(((n * n) << 32) / s3), qn ^ ds);
        n  = p * dm;
        j.rate_dpy = clamp_word(isqrt_w(((n * n) << 32) / s3), !(pn ^ ds));
        return j;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, n_cycles);
        n_fails++;
    endtask

    always @(posedge clk)
    begin
        rmj_pkg::jacobian_t w;
        if (rst_n && done)
        begin
            if (jac_pending.size() == 0)
                report_mismatch("unexpected result", 32'h0, 32'h0);
            else
            begin
                w = jac_pending.pop_front();
                if (jacobian.range_dpx !== w.range_dpx)
                    report_mismatch("range_dpx", jacobian.range_dpx, w.range_dpx);
                if (jacobian.range_dpy !== w.range_dpy)
                    report_mismatch("range_dpy", jacobian.range_dpy, w.range_dpy);
                if (jacobian.bearing_dpx !== w.bearing_dpx)
                    report_mismatch("bearing_dpx", jacobian.bearing_dpx, w.bearing_dpx);
                if (jacobian.bearing_dpy !== w.bearing_dpy)
                    report_mismatch("bearing_dpy", jacobian.bearing_dpy, w.bearing_dpy);
                if (jacobian.rate_dpx !== w.rate_dpx)
                    report_mismatch("rate_dpx", jacobian.rate_dpx, w.rate_dpx);
                if (jacobian.rate_dpy !== w.rate_dpy)
                    report_mismatch("rate_dpy", jacobian.rate_dpy, w.rate_dpy);
                if (jacobian.div_zero !== w.div_zero)
                    report_mismatch("div_zero", 32'(jacobian.div_zero), 32'(w.div_zero));
            end
        end
    end

    task automatic drain_all();
        while (jac_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_range_sq(input logic [31:0] val);
        drain_all();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready_s);
        cfg_valid <= 1'b0;
        min_range_sq_m = val;
    endtask

    // one transfer; start stays high unless a gap follows
    task automatic send_target(input rmj_pkg::target_t t, input logic chk,
                               input rmj_pkg::jacobian_t want, input bit may_idle);
        rmj_pkg::jacobian_t pred;
        pred = jacobian_predict(t, min_range_sq_m);
        if (chk && pred !== want)
            report_mismatch("table row vs predictor", pred[31:0], want[31:0]);
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start  <= 1'b1;
        target <= t;
        do @(posedge clk); while (busy_s);
        jac_pending.push_back(chk ? want : pred);
    endtask

    function automatic logic [31:0] rand_word();
        unique case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 65535)) - 32768);
            2: return 32'($signed($urandom_range(0, 33554431)) - 16777216);
            3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2097151)) - 1048576) << 4;
        endcase
    endfunction

    initial
    begin
        rmj_pkg::target_t   t;
        rmj_pkg::jacobian_t z;
        logic [31:0] thr_set[4];
        int        idx;
        z = '0;
        rows.push_back('{0, '{0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{0, '{32'h10000, 0, 0, 0}, 1, '{65536, 0, 0, 65536, 0, 0, 0}});
        rows.push_back('{0, '{1, 0, 0, 0}, 1, '{65536, 0, 0, 32'h7FFFFFFF, 0, 0, 0}});
        rows.push_back('{0, '{0, 1, 0, 0}, 1, '{0, 65536, 32'h80000000, 0, 0, 0, 0}});
        rows.push_back('{0, '{32'h80000000, 0, 0, 0}, 1,
                         '{-32'sd65536, 0, 0, -32'sd2, 0, 0, 0}});
        rows.push_back('{0, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000}, 0, z});
        rows.push_back('{0, '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, 0, z});
        rows.push_back('{0, '{32'h10000, 32'h10000, 32'h10000, 32'hFFFF0000}, 0, z});
        rows.push_back('{0, '{1, 1, 32'h7FFFFFFF, 32'h80000000}, 0, z});
        rows.push_back('{0, '{32'hFFFF0000, 32'h20000, 32'h30000, 32'hFFFD0000}, 0, z});
        rows.push_back('{0, '{32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0}, 0, z});
        rows.push_back('{1, '{256, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{1, '{257, 0, 0, 0}, 0, z});
        rows.push_back('{1, '{0, 32'hFFFFFF00, 32'h7FFFFFFF, 0}, 1, '{0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{32'hFFFFFFFF, '{32'h01000000, 0, 5, 7}, 0, z});
        rows.push_back('{32'hFFFFFFFF, '{32'h00FFFFFF, 0, 5, 7}, 1, '{0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{32'hFFFFFFFF, '{32'h80000000, 32'h7FFFFFFF, 32'h1, 32'hFFFFFFFF}, 0, z});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].thr != min_range_sq_m)
            begin
                start <= 1'b0;
                write_min_range_sq(rows[i].thr);
            end
            send_target(rows[i].tgt, rows[i].chk, rows[i].exp, 1'b1);
        end

        thr_set[0] = 32'h0;
        thr_set[1] = 32'hFFFFFFFF;
        thr_set[2] = $urandom;
        thr_set[3] = 32'h00010000;
        idx = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            start <= 1'b0;
            write_min_range_sq(thr_set[ph]);
            for (int k = 0; k < 285; k++)
            begin
                t.pos_x = rand_word();
                t.pos_y = rand_word();
                t.vel_x = rand_word();
                t.vel_y = rand_word();
                if (ph == 1 && k == 140)
                begin
                    start <= 1'b0;
                    drain_all();
                end
                send_target(t, 1'b0, z, (idx < 990) && ($urandom_range(0, 7) != 0));
                idx++;
            end
        end
        start <= 1'b0;

        while (jac_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rmj_pkg.sv
src/rmj_dly.sv
src/rmj_mul.sv
src/rmj_div.sv
src/rmj_sqrt.sv
src/radar_measurement_jacobian_core.sv
sim/tb_top.sv
